@@ hdl/ctrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrf_pkg: shared types and constants of the coalescing tile request queue
// Holds the sequencer state encoding, memory control bundle, register
// indexes, opcodes and fixed register widths.
// ----------------------------------------------------------------------------
package ctrf_pkg;

  // fixed register and field widths
  localparam int MAXQ_W      = 7;
  localparam int WIN_W       = 31;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_IDX_W   = 1;
  localparam int COUNT_OUT_W = 7;

  localparam logic [MAXQ_W-1:0] MAXQ_RESET = 7'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_WINDOW = 1'b1;

  // opcodes
  localparam logic OP_ACCEPT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_FINISH
  } state_t;

  // memory strobes from sequencer to store
  typedef struct packed {
    logic rd;
    logic coord_we;
    logic stamp_we;
  } mem_ctl_t;

endpackage

@@ hdl/ctrf_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrf_store: queue slot storage
// Coordinate memory and stamp memory, sharing one read address with a
// registered read and one write address with separate write strobes.
// ----------------------------------------------------------------------------
module ctrf_store #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 6,
  parameter int PAIR_BITS = 32,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  ctrf_pkg::mem_ctl_t    ctl,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [PAIR_BITS-1:0]  wr_coord,
  input  logic [TIME_BITS-1:0]  wr_stamp,
  output logic [PAIR_BITS-1:0]  rd_coord,
  output logic [TIME_BITS-1:0]  rd_stamp
);
  import ctrf_pkg::*;

  logic [PAIR_BITS-1:0] coord_mem [DEPTH];
  logic [TIME_BITS-1:0] stamp_mem [DEPTH];

  // coordinate memory
  always_ff @(posedge clk) begin
    if (ctl.coord_we) begin
      coord_mem[wr_addr] <= wr_coord;
    end
    if (ctl.rd) begin
      rd_coord <= coord_mem[rd_addr];
    end
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (ctl.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (ctl.rd) begin
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

@@ hdl/ctrf_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrf_seq: request sequencer
// Takes one word at a time, scans the pending slots through the store for a
// matching tile, restamps copies, appends or pops, and holds the result word.
// ----------------------------------------------------------------------------
module ctrf_seq #(
  parameter int QUEUE_DEPTH = 64,
  parameter int COORD_BITS  = 16,
  parameter int TIME_BITS   = 48,
  parameter int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [ctrf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctrf_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request channel
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  opcode,
  input  logic signed [COORD_BITS-1:0]          tile_x,
  input  logic signed [COORD_BITS-1:0]          tile_y,
  input  logic [TIME_BITS-1:0]                  now_ms,
  // response channel
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic                                  ok,
  output logic                                  merged,
  output logic signed [COORD_BITS-1:0]          popped_x,
  output logic signed [COORD_BITS-1:0]          popped_y,
  output logic [ctrf_pkg::COUNT_OUT_W-1:0]      pending_count,
  // store interface
  output ctrf_pkg::mem_ctl_t                    mem_ctl,
  output logic [ADDR_BITS-1:0]                  rd_addr,
  output logic [ADDR_BITS-1:0]                  wr_addr,
  output logic [2*COORD_BITS-1:0]               wr_coord,
  output logic [TIME_BITS-1:0]                  wr_stamp,
  input  logic [2*COORD_BITS-1:0]               rd_coord,
  input  logic [TIME_BITS-1:0]                  rd_stamp
);
  import ctrf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > MAXQ_W) ? CNT_W : MAXQ_W;
  localparam int DIF_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  function automatic logic [ADDR_BITS-1:0] ptr_inc(input logic [ADDR_BITS-1:0] p);
    logic [ADDR_BITS-1:0] r;
    if (p == ADDR_BITS'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = ADDR_BITS'(p + 1'b1);
    end
    return r;
  endfunction

  state_t state, state_next;

  // configuration registers
  logic [MAXQ_W-1:0] max_queue;
  logic [WIN_W-1:0]  merge_window;

  // queue pointers
  logic [ADDR_BITS-1:0] head, tail;
  logic [CNT_W-1:0]     count;

  // latched request
  logic                    op_q;
  logic [COORD_BITS-1:0]   x_q, y_q;
  logic [TIME_BITS-1:0]    now_q;

  // scan state
  logic [ADDR_BITS-1:0] scan_ptr;
  logic [CNT_W-1:0]     issue_left;
  logic                 rd_pend;
  logic [ADDR_BITS-1:0] rd_addr_q;
  logic                 found;
  logic                 merge_q;
  logic                 restamp_q;

  // pending result word
  logic                  res_ok, res_merged;
  logic [COORD_BITS-1:0] res_x, res_y;

  logic                  req_take, rsp_free;
  logic                  room, coord_hit, stamp_ok, first_hit, restamp_now, append;
  logic [CMP_W-1:0]      cap;
  logic [TIME_BITS-1:0]  age;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  assign req_stall = rst || (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // capacity and match logic
  always_comb begin
    if (CMP_W'(max_queue) > CMP_W'(QUEUE_DEPTH)) begin
      cap = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap = CMP_W'(max_queue);
    end
    room        = CMP_W'(count) < cap;
    age         = TIME_BITS'(now_q - rd_stamp);
    coord_hit   = rd_pend && (rd_coord == {x_q, y_q});
    stamp_ok    = (now_q >= rd_stamp) && (DIF_W'(age) < DIF_W'(merge_window));
    first_hit   = coord_hit && !found;
    restamp_now = first_hit ? (stamp_ok || room) : (coord_hit && restamp_q);
    append      = !(found && merge_q) && room;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (opcode == OP_POP) begin
            state_next = (count == '0) ? ST_FINISH : ST_POP_RD;
          end else begin
            state_next = (count == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_left == '0 && !rd_pend) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE:   state_next = ST_FINISH;
      ST_POP_RD:   state_next = ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory strobes and addresses
  always_comb begin
    mem_ctl  = '0;
    rd_addr  = head;
    wr_addr  = rd_addr_q;
    wr_coord = {x_q, y_q};
    wr_stamp = now_q;
    case (state)
      ST_SCAN: begin
        mem_ctl.rd       = (issue_left != '0);
        mem_ctl.stamp_we = restamp_now;
        rd_addr          = scan_ptr;
      end
      ST_DECIDE: begin
        mem_ctl.coord_we = append;
        mem_ctl.stamp_we = append;
        wr_addr          = tail;
      end
      ST_POP_RD: begin
        mem_ctl.rd = 1'b1;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_queue    <= MAXQ_RESET;
      merge_window <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_QUEUE:    max_queue    <= cfg_data[MAXQ_W-1:0];
        REG_MERGE_WINDOW: merge_window <= cfg_data[WIN_W-1:0];
        default:          max_queue    <= max_queue;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN) && mem_ctl.rd;
      if (state == ST_DECIDE && append) begin
        tail  <= ptr_inc(tail);
        count <= CNT_W'(count + 1'b1);
      end
      if (state == ST_POP_WAIT) begin
        head  <= ptr_inc(head);
        count <= CNT_W'(count - 1'b1);
      end
      if (state == ST_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request latch, scan bookkeeping and result word
  always_ff @(posedge clk) begin
    if (req_take) begin
      op_q       <= opcode;
      x_q        <= tile_x;
      y_q        <= tile_y;
      now_q      <= now_ms;
      scan_ptr   <= head;
      issue_left <= count;
      found      <= 1'b0;
      merge_q    <= 1'b0;
      restamp_q  <= 1'b0;
      res_ok     <= 1'b0;
      res_merged <= 1'b0;
      res_x      <= '0;
      res_y      <= '0;
    end
    if (state == ST_SCAN) begin
      if (mem_ctl.rd) begin
        scan_ptr   <= ptr_inc(scan_ptr);
        issue_left <= CNT_W'(issue_left - 1'b1);
      end
      rd_addr_q <= scan_ptr;
      if (first_hit) begin
        found     <= 1'b1;
        merge_q   <= stamp_ok;
        restamp_q <= stamp_ok || room;
      end
    end
    if (state == ST_DECIDE) begin
      res_ok     <= (found && merge_q) || room;
      res_merged <= found && merge_q;
    end
    if (state == ST_POP_WAIT) begin
      res_ok <= 1'b1;
      res_x  <= rd_coord[2*COORD_BITS-1:COORD_BITS];
      res_y  <= rd_coord[COORD_BITS-1:0];
    end
  end

  // response word
  assign count_ext = (CNT_W + COUNT_OUT_W)'(count);
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && rsp_free) begin
      ok            <= res_ok;
      merged        <= res_merged && (op_q == OP_ACCEPT);
      popped_x      <= signed'(res_x);
      popped_y      <= signed'(res_y);
      pending_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // occupancy never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  // a slot is only appended when room was there
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.coord_we |-> (state == ST_DECIDE && room))
    else $error("append without room");

  // a pop read only happens on a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP_RD) |-> (count != '0))
    else $error("pop read on empty queue");

  // a new response word comes only out of the finish step
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_FINISH))
    else $error("response raised outside finish");

  // an accepted word blocks the request side on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_take |=> req_stall)
    else $error("request side open while busy");
`endif

endmodule

@@ hdl/coalescing_tile_request_fifo_unit.sv @@
`timescale 1ns / 1ps
// Accept word: scan of every pending slot, then decide and finish (no scan when empty).
// Pop word: read of the head slot, then finish (finish only when empty).
// Throughput: one word at a time; the next word can be taken in the cycle after the
// response is registered. An accept's match scan walks the pending slots through the
// single read port of the slot memories.
// Reset (rst, synchronous): queue empty, max_queue 64, merge window 0.
// ----------------------------------------------------------------------------
// coalescing_tile_request_fifo_unit: coalescing tile request queue
// Bounded FIFO of tile coordinates that merges repeated requests inside a
// time window; an accepted request restamps every pending copy of its tile.
// ----------------------------------------------------------------------------
module coalescing_tile_request_fifo_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int COORD_BITS  = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [ctrf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctrf_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request channel
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  opcode,
  input  logic signed [COORD_BITS-1:0]          tile_x,
  input  logic signed [COORD_BITS-1:0]          tile_y,
  input  logic [TIME_BITS-1:0]                  now_ms,
  // response channel
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic                                  ok,
  output logic                                  merged,
  output logic signed [COORD_BITS-1:0]          popped_x,
  output logic signed [COORD_BITS-1:0]          popped_y,
  output logic [ctrf_pkg::COUNT_OUT_W-1:0]      pending_count
);
  import ctrf_pkg::*;

  localparam int ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  mem_ctl_t               mem_ctl;
  logic [ADDR_BITS-1:0]   rd_addr, wr_addr;
  logic [2*COORD_BITS-1:0] wr_coord, rd_coord;
  logic [TIME_BITS-1:0]   wr_stamp, rd_stamp;

  // sequencer
  ctrf_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COORD_BITS  (COORD_BITS),
    .TIME_BITS   (TIME_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .now_ms        (now_ms),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .ok            (ok),
    .merged        (merged),
    .popped_x      (popped_x),
    .popped_y      (popped_y),
    .pending_count (pending_count),
    .mem_ctl       (mem_ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wr_coord      (wr_coord),
    .wr_stamp      (wr_stamp),
    .rd_coord      (rd_coord),
    .rd_stamp      (rd_stamp)
  );

  // slot memories
  ctrf_store #(
    .DEPTH     (QUEUE_DEPTH),
    .ADDR_BITS (ADDR_BITS),
    .PAIR_BITS (2 * COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_coord (wr_coord),
    .wr_stamp (wr_stamp),
    .rd_coord (rd_coord),
    .rd_stamp (rd_stamp)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the coalescing tile request queue
// Sends accept and pop words through the request channel and tracks the
// queue in a local shadow: slots, stamps, capacity and merge window. Each
// response word is compared field by field against the shadow's answer.
// Random gaps and stalls hit both channels. One long response hold fills
// the block so it stalls its request side. Register settings are changed
// between phases, including zero capacity, capacity above depth, and the
// smallest and largest merge windows.
// ----------------------------------------------------------------------------
module tb_top;
  import ctrf_pkg::*;

  localparam int DEPTH  = 64;
  localparam int XY_W   = 16;
  localparam int TIME_W = 48;

  typedef struct packed {
    logic                    op;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic [TIME_W-1:0]       now;
  } tile_req_t;

  typedef struct packed {
    logic                    ok;
    logic                    merged;
    logic signed [XY_W-1:0]  px;
    logic signed [XY_W-1:0]  py;
    logic [COUNT_OUT_W-1:0]  count;
  } tile_rsp_t;

  // clock, reset and block ports
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_MAX_QUEUE;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic                        opcode = OP_ACCEPT;
  logic signed [XY_W-1:0]      tile_x = '0;
  logic signed [XY_W-1:0]      tile_y = '0;
  logic [TIME_W-1:0]           now_ms = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  logic                        ok;
  logic                        merged;
  logic signed [XY_W-1:0]      popped_x;
  logic signed [XY_W-1:0]      popped_y;
  logic [COUNT_OUT_W-1:0]      pending_count;

  // shadow of the queue and its registers
  logic signed [XY_W-1:0]      slot_x [DEPTH];
  logic signed [XY_W-1:0]      slot_y [DEPTH];
  logic [TIME_W-1:0]           slot_stamp [DEPTH];
  int                          slot_count = 0;
  logic [MAXQ_W-1:0]           cap_reg = MAXQ_RESET;
  logic [WIN_W-1:0]            window_reg = '0;

  // word traffic bookkeeping
  tile_req_t                   req_todo [$];
  tile_rsp_t                   due_rsp [$];
  tile_req_t                   on_wire;
  tile_rsp_t                   want;
  int                          words_queued = 0;
  int                          words_done = 0;
  int                          gap_left = 0;
  int                          stall_left = 0;
  int                          hold_left = 0;
  bit                          hold_done = 1'b0;
  bit                          calm = 1'b0;
  bit                          failed = 1'b0;

  // stimulus helpers: tile pool for repeats and a running clock
  logic signed [XY_W-1:0]      pool_x [6];
  logic signed [XY_W-1:0]      pool_y [6];
  logic [TIME_W-1:0]           clock_ms = '0;

  coalescing_tile_request_fifo_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .now_ms        (now_ms),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .ok            (ok),
    .merged        (merged),
    .popped_x      (popped_x),
    .popped_y      (popped_y),
    .pending_count (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one word to the shadow queue and return the response it must give
  function automatic tile_rsp_t predict_tile_queue(tile_req_t r);
    tile_rsp_t         o;
    int                i;
    int                cap;
    bit                found;
    bit                take;
    logic [TIME_W-1:0] stamp;
    o = '0;
    found = 1'b0;
    take = 1'b0;
    stamp = '0;
    if (r.op == OP_ACCEPT) begin
      cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
      for (i = 0; i < slot_count; i++) begin
        if (!found && slot_x[i] == r.x && slot_y[i] == r.y) begin
          found = 1'b1;
          stamp = slot_stamp[i];
        end
      end
      // merge only on a past stamp strictly inside the window
      if (found && r.now >= stamp && (r.now - stamp) < window_reg) begin
        take = 1'b1;
        o.merged = 1'b1;
      end else if (slot_count < cap) begin
        take = 1'b1;
      end
      if (take) begin
        for (i = 0; i < slot_count; i++)
          if (slot_x[i] == r.x && slot_y[i] == r.y) slot_stamp[i] = r.now;
        if (!o.merged) begin
          slot_x[slot_count] = r.x;
          slot_y[slot_count] = r.y;
          slot_stamp[slot_count] = r.now;
          slot_count++;
        end
        o.ok = 1'b1;
      end
    end else if (slot_count > 0) begin
      o.ok = 1'b1;
      o.px = slot_x[0];
      o.py = slot_y[0];
      for (i = 1; i < slot_count; i++) begin
        slot_x[i-1] = slot_x[i];
        slot_y[i-1] = slot_y[i];
        slot_stamp[i-1] = slot_stamp[i];
      end
      slot_count--;
    end
    o.count = slot_count[COUNT_OUT_W-1:0];
    return o;
  endfunction

  // request driver: one word on the wire, replaced once taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall)
        due_rsp = {due_rsp, predict_tile_queue(on_wire)};
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          req_valid <= 1'b0;
        end else if (req_todo.size() != 0) begin
          on_wire = req_todo.pop_front();
          req_valid <= 1'b1;
          opcode <= on_wire.op;
          tile_x <= on_wire.x;
          tile_y <= on_wire.y;
          now_ms <= on_wire.now;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: check taken words, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          $error("response word with no request outstanding");
          failed = 1'b1;
        end else begin
          want = due_rsp.pop_front();
          words_done++;
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            failed = 1'b1;
          end
          if (merged !== want.merged) begin
            $error("merged: expected %0d, got %0d", want.merged, merged);
            failed = 1'b1;
          end
          if (popped_x !== want.px) begin
            $error("popped_x: expected %0d, got %0d", want.px, popped_x);
            failed = 1'b1;
          end
          if (popped_y !== want.py) begin
            $error("popped_y: expected %0d, got %0d", want.py, popped_y);
            failed = 1'b1;
          end
          if (pending_count !== want.count) begin
            $error("pending_count: expected %0d, got %0d", want.count, pending_count);
            failed = 1'b1;
          end
        end
      end
      // one long hold mid-run so the block backs up into the request side
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && words_done == 300) begin
        hold_done = 1'b1;
        hold_left = 199;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic queue_word(tile_req_t r);
    req_todo = {req_todo, r};
    words_queued++;
  endtask

  task automatic accept_word(logic signed [XY_W-1:0] x, logic signed [XY_W-1:0] y,
                             logic [TIME_W-1:0] now);
    tile_req_t r;
    r.op = OP_ACCEPT;
    r.x = x;
    r.y = y;
    r.now = now;
    queue_word(r);
  endtask

  // pop words carry random junk in the unused fields
  task automatic pop_word();
    tile_req_t   r;
    logic [63:0] w;
    w = {$urandom, $urandom};
    r.op = OP_POP;
    r.x = w[15:0];
    r.y = w[31:16];
    r.now = w[63:16];
    queue_word(r);
  endtask

  // wait until every queued word has its response back
  task automatic drain();
    while (words_done != words_queued) @(posedge clk);
    @(posedge clk);
  endtask

  // write both registers while the block is idle; junk above max_queue's width
  task automatic set_config(logic [MAXQ_W-1:0] cap, logic [WIN_W-1:0] win);
    logic [CFG_DATA_W-MAXQ_W-1:0] junk;
    junk = (CFG_DATA_W-MAXQ_W)'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_QUEUE;
    cfg_data <= {junk, cap};
    @(posedge clk);
    cfg_index <= REG_MERGE_WINDOW;
    cfg_data <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap;
    window_reg = win;
  endtask

  // fresh tile pool; some share a column or row with tile 0
  task automatic new_pool();
    int i;
    for (i = 0; i < 6; i++) begin
      pool_x[i] = XY_W'($urandom);
      pool_y[i] = XY_W'($urandom);
    end
    pool_x[1] = pool_x[0];
    pool_y[2] = pool_y[0];
  endtask

  // mostly repeats from the pool on a forward clock, with jumps and rewinds
  task automatic run_random(int count, int unsigned step_max, int pop_pct);
    tile_req_t   r;
    logic [63:0] w;
    int          k;
    int          roll;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < pop_pct) begin
        pop_word();
      end else begin
        w = {$urandom, $urandom};
        r.op = OP_ACCEPT;
        if ($urandom_range(0, 9) < 8) begin
          roll = $urandom_range(0, 5);
          r.x = pool_x[roll];
          r.y = pool_y[roll];
        end else begin
          r.x = w[15:0];
          r.y = w[31:16];
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          clock_ms = w[63:16];
          r.now = clock_ms;
        end else if (roll < 12) begin
          r.now = clock_ms - $urandom_range(1, step_max);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          r.now = clock_ms;
        end
        queue_word(r);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    logic [WIN_W-1:0] win;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: depth 64, no merging
    pop_word();
    accept_word(-16'sd32768, 16'sd32767, '0);
    accept_word(16'sd32767, -16'sd32768, {TIME_W{1'b1}});
    accept_word(-16'sd32768, 16'sd32767, 48'd5);
    pop_word();
    pop_word();
    pop_word();
    pop_word();
    drain();

    // two slots, window 100: merge, window edge, full, future stamp
    set_config(7'd2, 31'd100);
    accept_word(16'sd7, -16'sd3, 48'd1000);
    accept_word(16'sd7, -16'sd3, 48'd1099);
    accept_word(16'sd7, -16'sd3, 48'd1199);
    accept_word(16'sd7, 16'sd3, 48'd1200);
    accept_word(16'sd7, -16'sd3, 48'd1150);
    accept_word(16'sd7, -16'sd3, 48'd1250);
    pop_word();
    pop_word();
    pop_word();
    drain();

    // zero capacity, widest window
    set_config(7'd0, {WIN_W{1'b1}});
    accept_word(16'sd1, 16'sd1, 48'd0);
    pop_word();
    drain();

    // capacity above depth, no merging: fill to the top
    set_config(7'd127, '0);
    new_pool();
    run_random(150, 50, 10);
    drain();

    // full depth, window of one: merges only at the same millisecond
    set_config(MAXQ_RESET, 31'd1);
    new_pool();
    run_random(200, 2, 45);
    drain();

    set_config(7'd5, 31'd500);
    new_pool();
    run_random(200, 300, 45);
    drain();

    set_config(7'd1, {WIN_W{1'b1}});
    new_pool();
    run_random(100, 1000, 50);
    drain();

    win = WIN_W'($urandom);
    set_config(7'($urandom_range(1, 64)), win);
    new_pool();
    run_random(150, (win >> 1) + 1, 45);
    drain();

    // closing stretch with no gaps or stalls
    calm = 1'b1;
    set_config(MAXQ_RESET, 31'd50);
    new_pool();
    run_random(150, 40, 40);
    drain();

    repeat (80) @(posedge clk);
    if (due_rsp.size() != 0) begin
      $error("%0d responses never arrived", due_rsp.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
